// ----- src/aps_pkg.sv -----
// Shared types and constants for the Annex B parameter-set extractor.
// Used by the scanner, the command queue, the result sequencer and the top level.
// No dependencies.
package aps_pkg;

    // Codec selections held in the mode register.
    localparam logic [1:0] CODEC_H264 = 2'd0;
    localparam logic [1:0] CODEC_H265 = 2'd1;
    localparam logic [1:0] CODEC_JPEG = 2'd2;

    // NAL unit types of interest.
    localparam logic [4:0] H264_SPS = 5'd7;
    localparam logic [4:0] H264_PPS = 5'd8;
    localparam logic [4:0] H264_IDR = 5'd5;
    localparam logic [5:0] H265_VPS = 6'd32;
    localparam logic [5:0] H265_SPS = 6'd33;
    localparam logic [5:0] H265_PPS = 6'd34;
    localparam logic [5:0] H265_IDR_W_RADL = 6'd19;
    localparam logic [5:0] H265_IDR_N_LP = 6'd20;

    // Start code terminator byte.
    localparam logic [7:0] START_CODE_ONE = 8'h01;

    // Command queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

    // Result kinds.
    localparam logic KIND_COPY = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // One command describes all results caused by one input beat, in order:
    // leading zeros, the start code byte 01, a data byte, trailing zeros, summary.
    typedef struct packed {
        logic [1:0] pre_zeros;
        logic       emit_one;
        logic       emit_byte;
        logic [7:0] data;
        logic [1:0] post_zeros;
        logic       summary;
        logic       keyframe;
        logic       found;
    } t_cmd;

endpackage

// ----- src/aps_front.sv -----
// Byte scanner: finds start codes, types NAL unit headers and builds at most one
// result command per input beat. Holds the codec mode register.
// Depends on aps_pkg.
module aps_front
    import aps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_wr_data,
    input  logic       i_accept,
    input  logic [7:0] i_stream_byte,
    input  logic       i_final_byte,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd
);

    logic [1:0] r_codec_mode;
    logic [1:0] r_zero_run, n_zero_run;
    logic       r_awaiting, n_awaiting;
    logic [2:0] r_sc_len, n_sc_len;
    logic       r_copying, n_copying;
    logic       r_keyframe, n_keyframe;
    logic       r_found, n_found;

    logic [4:0] h264_type;
    logic [5:0] h265_type;
    logic       hdr_copy;
    logic       hdr_key;
    logic       active;
    t_cmd       cmd;

    // Header classification by codec.
    always_comb begin
        h264_type = i_stream_byte[4:0];
        h265_type = i_stream_byte[6:1];
        hdr_copy  = 1'b0;
        hdr_key   = 1'b0;
        unique case (r_codec_mode)
            CODEC_H264: begin
                hdr_copy = (h264_type == H264_SPS) || (h264_type == H264_PPS);
                hdr_key  = (h264_type == H264_IDR);
            end
            CODEC_H265: begin
                hdr_copy = (h265_type == H265_VPS) || (h265_type == H265_SPS)
                        || (h265_type == H265_PPS);
                hdr_key  = (h265_type == H265_IDR_W_RADL) || (h265_type == H265_IDR_N_LP);
            end
            default: begin
                hdr_copy = 1'b0;
                hdr_key  = 1'b0;
            end
        endcase
        active = (r_codec_mode == CODEC_H264) || (r_codec_mode == CODEC_H265);
    end

    // Scan state update and command build for the accepted beat.
    always_comb begin
        n_zero_run = r_zero_run;
        n_awaiting = r_awaiting;
        n_sc_len   = r_sc_len;
        n_copying  = r_copying;
        n_keyframe = r_keyframe;
        n_found    = r_found;
        cmd        = '0;
        if (i_accept) begin
            if (r_awaiting) begin
                n_awaiting = 1'b0;
                if (i_stream_byte == 8'd0) begin
                    n_copying  = 1'b0;
                    n_zero_run = 2'd1;
                end else begin
                    if (hdr_key) begin
                        n_keyframe = 1'b1;
                    end
                    if (hdr_copy) begin
                        cmd.pre_zeros = 2'(r_sc_len - 3'd1);
                        cmd.emit_one  = 1'b1;
                        cmd.emit_byte = 1'b1;
                        cmd.data      = i_stream_byte;
                        n_found       = 1'b1;
                    end
                    n_copying  = hdr_copy;
                    n_zero_run = 2'd0;
                end
            end else if (i_stream_byte == 8'd0) begin
                if (r_zero_run == 2'd3) begin
                    // Extra zero releases the oldest held zero to the current unit.
                    if (r_copying) begin
                        cmd.pre_zeros = 2'd1;
                    end
                end else begin
                    n_zero_run = r_zero_run + 2'd1;
                end
            end else if (i_stream_byte == START_CODE_ONE && r_zero_run >= 2'd2
                         && !(i_final_byte && r_zero_run == 2'd2)) begin
                n_sc_len   = {1'b0, r_zero_run} + 3'd1;
                n_awaiting = 1'b1;
                n_copying  = 1'b0;
                n_zero_run = 2'd0;
            end else begin
                // Held zeros belong to the current unit.
                if (r_copying) begin
                    cmd.pre_zeros = r_zero_run;
                    cmd.emit_byte = 1'b1;
                    cmd.data      = i_stream_byte;
                end
                n_zero_run = 2'd0;
            end

            // End of buffer: flush held zeros, report, clear the scan.
            if (i_final_byte) begin
                cmd.post_zeros = n_copying ? n_zero_run : 2'd0;
                cmd.summary    = 1'b1;
                cmd.keyframe   = active & n_keyframe;
                cmd.found      = active & n_found;
                n_zero_run     = 2'd0;
                n_awaiting     = 1'b0;
                n_sc_len       = 3'd0;
                n_copying      = 1'b0;
                n_keyframe     = 1'b0;
                n_found        = 1'b0;
            end
        end
    end

    assign o_cmd       = cmd;
    assign o_cmd_valid = i_accept && (cmd.pre_zeros != 2'd0 || cmd.emit_one || cmd.emit_byte
                                      || cmd.post_zeros != 2'd0 || cmd.summary);

    // Mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec_mode <= CODEC_H264;
        end else if (i_cfg_wr_en) begin
            r_codec_mode <= i_cfg_wr_data;
        end
    end

    // Scan state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run <= 2'd0;
            r_awaiting <= 1'b0;
            r_sc_len   <= 3'd0;
            r_copying  <= 1'b0;
            r_keyframe <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_zero_run <= n_zero_run;
            r_awaiting <= n_awaiting;
            r_sc_len   <= n_sc_len;
            r_copying  <= n_copying;
            r_keyframe <= n_keyframe;
            r_found    <= n_found;
        end
    end

endmodule

// ----- src/aps_cmd_queue.sv -----
// Short command queue between the scanner and the result sequencer.
// Depends on aps_pkg.
module aps_cmd_queue
    import aps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_en,
    input  t_cmd i_wr_cmd,
    input  logic i_rd_en,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic                do_wr;
    logic                do_rd;

    assign o_empty = (r_count == QUEUE_CW'(0));
    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign do_wr   = i_wr_en && !o_full;
    assign do_rd   = i_rd_en && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + QUEUE_CW'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - QUEUE_CW'(1);
            end
        end
    end

endmodule

// ----- src/aps_back.sv -----
// Result sequencer: expands each queued command into result beats, one per cycle
// unless a held output stalls it, via a registered output stage. Depends on aps_pkg.
module aps_back
    import aps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  logic       i_q_empty,
    output logic       o_q_pop,
    input  logic       pop,
    output logic       empty,
    output logic       o_result_kind,
    output logic [7:0] o_copied_byte,
    output logic       o_keyframe_seen,
    output logic       o_params_found,
    output logic       o_last_result
);

    t_cmd       r_cmd, n_cmd;
    logic       r_busy, n_busy;
    logic       r_out_valid;
    logic       r_kind;
    logic [7:0] r_byte;
    logic       r_kf;
    logic       r_pf;
    logic       r_last;

    logic       out_free;
    logic       step;
    logic       remain;
    logic       load;
    logic       e_kind;
    logic [7:0] e_byte;
    logic       e_kf;
    logic       e_pf;

    assign out_free = !r_out_valid || pop;
    assign step     = r_busy && out_free;

    // Pick the next result of the working command and retire it.
    always_comb begin
        n_cmd  = r_cmd;
        e_kind = KIND_COPY;
        e_byte = 8'd0;
        e_kf   = 1'b0;
        e_pf   = 1'b0;
        if (step) begin
            if (r_cmd.pre_zeros != 2'd0) begin
                n_cmd.pre_zeros = r_cmd.pre_zeros - 2'd1;
            end else if (r_cmd.emit_one) begin
                e_byte         = START_CODE_ONE;
                n_cmd.emit_one = 1'b0;
            end else if (r_cmd.emit_byte) begin
                e_byte          = r_cmd.data;
                n_cmd.emit_byte = 1'b0;
            end else if (r_cmd.post_zeros != 2'd0) begin
                n_cmd.post_zeros = r_cmd.post_zeros - 2'd1;
            end else begin
                e_kind        = KIND_SUMMARY;
                e_kf          = r_cmd.keyframe;
                e_pf          = r_cmd.found;
                n_cmd.summary = 1'b0;
            end
        end
        remain = (n_cmd.pre_zeros != 2'd0) || n_cmd.emit_one || n_cmd.emit_byte
              || (n_cmd.post_zeros != 2'd0) || n_cmd.summary;
        // Take the next command when idle or when this one just finished.
        load   = !r_busy || (step && !remain);
        n_busy = r_busy;
        if (load) begin
            n_busy = !i_q_empty;
            if (!i_q_empty) begin
                n_cmd = i_head;
            end
        end
    end

    assign o_q_pop = load && !i_q_empty;

    // Working command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    // Output stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output stage payload.
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_kind <= e_kind;
            r_byte <= e_byte;
            r_kf   <= e_kf;
            r_pf   <= e_pf;
            r_last <= !remain;
        end
    end

    assign empty           = !r_out_valid;
    assign o_result_kind   = r_kind;
    assign o_copied_byte   = r_byte;
    assign o_keyframe_seen = r_kf;
    assign o_params_found  = r_pf;
    assign o_last_result   = r_last;

endmodule

// ----- src/annexb_parameter_set_extractor.sv -----
// Annex B parameter-set extractor: takes one stream byte per cycle as long as
// full is low. The scanner classifies each byte in the cycle it is accepted and
// places a result command in a four-entry queue; the sequencer drains that queue
// at one result beat per cycle unless the output is held, through a registered
// output stage. One byte can cause up to six results (a four-byte start code,
// header and summary), so a burst of copied bytes with a slow consumer fills
// the queue and raises full until the sequencer catches up. The user must write
// the codec mode through i_cfg_wr_en only while the block is idle; the block itself
// does not enforce this. Depends on aps_pkg, aps_front, aps_cmd_queue, aps_back.
module annexb_parameter_set_extractor
    import aps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_wr_data,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_stream_byte,
    input  logic       i_final_byte,
    input  logic       pop,
    output logic       empty,
    output logic       o_result_kind,
    output logic [7:0] o_copied_byte,
    output logic       o_keyframe_seen,
    output logic       o_params_found,
    output logic       o_last_result
);

    logic accept;
    logic cmd_valid;
    t_cmd cmd;
    t_cmd head;
    logic q_empty;
    logic q_pop;

    assign accept = push && !full;

    // Scanner.
    aps_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_stream_byte (i_stream_byte),
        .i_final_byte  (i_final_byte),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd)
    );

    // Command queue.
    aps_cmd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (cmd_valid),
        .i_wr_cmd (cmd),
        .i_rd_en  (q_pop),
        .o_head   (head),
        .o_empty  (q_empty),
        .o_full   (full)
    );

    // Result sequencer.
    aps_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_q_empty       (q_empty),
        .o_q_pop         (q_pop),
        .pop             (pop),
        .empty           (empty),
        .o_result_kind   (o_result_kind),
        .o_copied_byte   (o_copied_byte),
        .o_keyframe_seen (o_keyframe_seen),
        .o_params_found  (o_params_found),
        .o_last_result   (o_last_result)
    );

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the Annex B parameter-set extractor.
// Predicts every result beat from the stream bytes and compares it field by field.
// Depends on aps_pkg and annexb_parameter_set_extractor.
`timescale 1ns / 1ps

module tb;
    import aps_pkg::*;

    // Mode 3 is not a defined codec; the block must treat it like JPEG.
    localparam logic [1:0] CODEC_UNDEFINED = 2'd3;
    localparam logic [7:0] ZERO_BYTE = 8'h00;
    localparam int RESET_CYCLES = 7;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int RANDOM_ITEMS = 150;
    localparam int MIN_PHASES = 4;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       keyframe;
        logic       found;
        logic       last;
    } t_beat;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_stim;

    // A directed row; kf and pf are the typed summary when typed is set.
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       typed;
        logic       kf;
        logic       pf;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [1:0] i_cfg_wr_data;
    logic       push;
    logic       full;
    logic [7:0] i_stream_byte;
    logic       i_final_byte;
    logic       pop;
    logic       empty;
    logic       o_result_kind;
    logic [7:0] o_copied_byte;
    logic       o_keyframe_seen;
    logic       o_params_found;
    logic       o_last_result;

    annexb_parameter_set_extractor i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .push           (push),
        .full           (full),
        .i_stream_byte  (i_stream_byte),
        .i_final_byte   (i_final_byte),
        .pop            (pop),
        .empty          (empty),
        .o_result_kind  (o_result_kind),
        .o_copied_byte  (o_copied_byte),
        .o_keyframe_seen(o_keyframe_seen),
        .o_params_found (o_params_found),
        .o_last_result  (o_last_result)
    );

    // Scanner state as the predictor sees it.
    logic [1:0] codec = CODEC_H264;
    logic [1:0] held_zeros = '0;
    logic       hdr_pending = 1'b0;
    logic [2:0] sc_len = '0;
    logic       in_param_unit = 1'b0;
    logic       kf_flag = 1'b0;
    logic       ps_flag = 1'b0;

    t_beat expected_beats[$];
    t_stim stim_q[$];
    int    errors = 0;
    int    beat_no = 0;
    int    random_items = 0;
    int    burst_left = 0;
    int    hold_requests = 0;
    int    stall_cycles = 0;

    // Two buffers in H.264: skipped lead-in, four-byte start code, copied SPS,
    // zero run of four, 00 00 01 as the last bytes, IDR, a header of 00, a
    // dropped held zero and a four-byte start code ending the buffer.
    t_stim_row directed_rows [0:26] = '{
        '{8'hAB, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h67, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h01, 1'b1, 1'b1, 1'b0, 1'b1},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h65, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h7F, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h01, 1'b1, 1'b1, 1'b1, 1'b0}
    };

    logic [1:0] phase_modes [0:6] = '{CODEC_H265, CODEC_JPEG, CODEC_H264, CODEC_UNDEFINED,
                                      CODEC_H265, CODEC_H264, CODEC_JPEG};

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Predicted beats.
    task automatic push_copy(input logic [7:0] data);
        expected_beats.push_back('{KIND_COPY, data, 1'b0, 1'b0, 1'b0});
    endtask

    task automatic push_zeros(input int count);
        repeat (count) push_copy(ZERO_BYTE);
    endtask

    // Works out the beats that one accepted stream byte causes.
    task automatic scan_annexb_byte(input logic [7:0] data, input logic fin);
        int         first;
        logic       copy;
        logic       kf;
        logic [4:0] t264;
        logic [5:0] t265;
        t_beat      tail;

        first = expected_beats.size();
        if (hdr_pending) begin
            hdr_pending = 1'b0;
            if (data == ZERO_BYTE) begin
                in_param_unit = 1'b0;
                held_zeros = 2'd1;
            end else begin
                copy = 1'b0;
                kf = 1'b0;
                t264 = data[4:0];
                t265 = data[6:1];
                if (codec == CODEC_H264) begin
                    copy = (t264 == H264_SPS) || (t264 == H264_PPS);
                    kf = (t264 == H264_IDR);
                end else if (codec == CODEC_H265) begin
                    copy = (t265 == H265_VPS) || (t265 == H265_SPS) || (t265 == H265_PPS);
                    kf = (t265 == H265_IDR_W_RADL) || (t265 == H265_IDR_N_LP);
                end
                if (kf) kf_flag = 1'b1;
                if (copy) begin
                    push_zeros(int'(sc_len) - 1);
                    push_copy(START_CODE_ONE);
                    push_copy(data);
                    ps_flag = 1'b1;
                end
                in_param_unit = copy;
                held_zeros = '0;
            end
        end else if (data == ZERO_BYTE) begin
            // A fourth zero pushes the oldest held zero into the current unit.
            if (held_zeros == 2'd3) begin
                if (in_param_unit) push_copy(ZERO_BYTE);
            end else begin
                held_zeros = held_zeros + 2'd1;
            end
        end else if (data == START_CODE_ONE && held_zeros >= 2'd2
                     && !(fin && held_zeros == 2'd2)) begin
            sc_len = {1'b0, held_zeros} + 3'd1;
            hdr_pending = 1'b1;
            in_param_unit = 1'b0;
            held_zeros = '0;
        end else begin
            if (in_param_unit) begin
                push_zeros(int'(held_zeros));
                push_copy(data);
            end
            held_zeros = '0;
        end

        // End of buffer: flush held zeros, then the summary, then a clean scan.
        if (fin) begin
            if (in_param_unit) push_zeros(int'(held_zeros));
            if (codec == CODEC_H264 || codec == CODEC_H265)
                expected_beats.push_back('{KIND_SUMMARY, ZERO_BYTE, kf_flag, ps_flag, 1'b0});
            else
                expected_beats.push_back('{KIND_SUMMARY, ZERO_BYTE, 1'b0, 1'b0, 1'b0});
            held_zeros = '0;
            hdr_pending = 1'b0;
            sc_len = '0;
            in_param_unit = 1'b0;
            kf_flag = 1'b0;
            ps_flag = 1'b0;
        end

        if (expected_beats.size() > first) begin
            tail = expected_beats.pop_back();
            tail.last = 1'b1;
            expected_beats.push_back(tail);
        end
    endtask

    // Sender side.
    task automatic send_byte(input logic [7:0] data, input logic fin);
        @(negedge i_clk);
        push = 1'b1;
        i_stream_byte = data;
        i_final_byte = fin;
        do @(posedge i_clk); while (full);
        scan_annexb_byte(data, fin);
    endtask

    task automatic idle_for(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            push = 1'b0;
            i_stream_byte = 8'($urandom);
            i_final_byte = 1'($urandom);
        end
    endtask

    // Writes the codec mode once every expected beat has drained.
    task automatic set_codec(input logic [1:0] mode);
        @(negedge i_clk);
        push = 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_wr_data = mode;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = 2'($urandom);
        codec = mode;
    endtask

    task automatic queue_byte(input logic [7:0] data, input logic fin);
        stim_q.push_back('{data, fin});
    endtask

    // Header byte with random side bits; mostly parameter sets and keyframes.
    function automatic logic [7:0] pick_header(input logic [1:0] mode);
        logic [7:0] hdr;
        int         cls;
        logic       as_h265;

        hdr = 8'($urandom);
        cls = $urandom_range(0, 9);
        as_h265 = (mode == CODEC_H265) || (mode[1] && $urandom_range(0, 1) == 1);
        if (cls == 0) begin
            hdr = ZERO_BYTE;
        end else if (cls <= 4) begin
            if (as_h265) hdr[6:1] = 6'($urandom_range(int'(H265_VPS), int'(H265_PPS)));
            else hdr[4:0] = ($urandom_range(0, 1) == 1) ? H264_SPS : H264_PPS;
        end else if (cls <= 6) begin
            if (as_h265) hdr[6:1] = ($urandom_range(0, 1) == 1) ? H265_IDR_W_RADL : H265_IDR_N_LP;
            else hdr[4:0] = H264_IDR;
        end
        return hdr;
    endfunction

    // One buffer of well-formed units with random content and a random ending.
    task automatic gen_buffer(input logic [1:0] mode);
        int zeros;
        int r;

        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) queue_byte(8'($urandom), 1'b0);
        repeat ($urandom_range(1, 3)) begin
            r = $urandom_range(0, 9);
            zeros = (r < 4) ? 2 : (r < 8) ? 3 : $urandom_range(4, 6);
            repeat (zeros) queue_byte(ZERO_BYTE, 1'b0);
            queue_byte(START_CODE_ONE, 1'b0);
            queue_byte(pick_header(mode), 1'b0);
            repeat ($urandom_range(0, 8)) begin
                if ($urandom_range(0, 5) == 0) begin
                    queue_byte(ZERO_BYTE, 1'b0);
                    queue_byte(ZERO_BYTE, 1'b0);
                end
                queue_byte(8'($urandom), 1'b0);
            end
        end
        case ($urandom_range(0, 5))
            0, 1: stim_q[stim_q.size() - 1].fin = 1'b1;
            2: begin
                queue_byte(ZERO_BYTE, 1'b0);
                queue_byte(ZERO_BYTE, 1'b0);
                queue_byte(START_CODE_ONE, 1'b1);
            end
            3: begin
                repeat (3) queue_byte(ZERO_BYTE, 1'b0);
                queue_byte(START_CODE_ONE, 1'b1);
            end
            4: begin
                queue_byte(ZERO_BYTE, 1'b0);
                queue_byte(ZERO_BYTE, 1'b1);
            end
            // Otherwise the buffer stays open into whatever is sent next.
            default: ;
        endcase
    endtask

    // Sends the queued bytes in bursts, with random gaps between them unless no_gaps is set or the run is steady.
    task automatic drive_stream(input bit no_gaps);
        t_stim s;
        bit    steady;

        steady = no_gaps || ($urandom_range(0, 3) == 0);
        while (stim_q.size() != 0) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                if (!steady && $urandom_range(0, 2) != 0) idle_for($urandom_range(1, 6));
            end
            burst_left--;
            s = stim_q.pop_front();
            send_byte(s.data, s.fin);
            random_items++;
        end
    endtask

    // Stimulus.
    initial begin
        t_beat     summary;
        t_stim_row row;
        int        phase;

        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        push = 1'b0;
        i_stream_byte = '0;
        i_final_byte = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows run in the reset mode, H.264.
        for (int i = 0; i <= 26; i++) begin
            row = directed_rows[i];
            if ($urandom_range(0, 3) == 0) idle_for($urandom_range(1, 3));
            send_byte(row.data, row.fin);
            if (row.typed) begin
                summary = expected_beats.pop_back();
                summary.keyframe = row.kf;
                summary.found = row.pf;
                expected_beats.push_back(summary);
            end
        end

        // Long receiver hold-off while a long SPS streams in without gaps.
        set_codec(CODEC_H264);
        repeat (3) queue_byte(ZERO_BYTE, 1'b0);
        queue_byte(START_CODE_ONE, 1'b0);
        queue_byte({3'($urandom), H264_SPS}, 1'b0);
        repeat (20) queue_byte(8'($urandom_range(1, 255)), 1'b0);
        stim_q[stim_q.size() - 1].fin = 1'b1;
        hold_requests++;
        drive_stream(1'b1);

        // Random phases, cycling through every codec mode.
        phase = 0;
        while (random_items < RANDOM_ITEMS || phase < MIN_PHASES) begin
            set_codec(phase_modes[phase % 7]);
            repeat (2) gen_buffer(codec);
            drive_stream(1'b0);
            phase++;
        end

        // Drain and let the block settle.
        @(negedge i_clk);
        push = 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Receiver: stalls on a pattern of its own, plus one long hold-off.
    initial begin
        int seg_left;
        int style;
        int holds_done;

        pop = 1'b0;
        seg_left = 0;
        style = 0;
        holds_done = 0;
        forever begin
            @(negedge i_clk);
            if (hold_requests > holds_done) begin
                holds_done++;
                pop = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (seg_left == 0) begin
                style = $urandom_range(0, 3);
                seg_left = $urandom_range(1, 40);
            end
            seg_left--;
            case (style)
                0, 1: pop = 1'b1;
                2: pop = 1'($urandom_range(0, 1));
                default: pop = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH beat %0d at %0t: %s got %0h, expected %0h",
                 beat_no, $realtime, what, got, want);
        errors++;
    endtask

    // Compares each accepted result beat with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_beat want;
        if (i_rst_n && pop && !empty) begin
            beat_no++;
            if (expected_beats.size() == 0) begin
                report_mismatch("unexpected beat, copied_byte", o_copied_byte, 0);
            end else begin
                want = expected_beats.pop_front();
                if (o_result_kind !== want.kind)
                    report_mismatch("result_kind", o_result_kind, want.kind);
                if (o_copied_byte !== want.data)
                    report_mismatch("copied_byte", o_copied_byte, want.data);
                if (o_keyframe_seen !== want.keyframe)
                    report_mismatch("keyframe_seen", o_keyframe_seen, want.keyframe);
                if (o_params_found !== want.found)
                    report_mismatch("params_found", o_params_found, want.found);
                if (o_last_result !== want.last)
                    report_mismatch("last_result", o_last_result, want.last);
            end
        end
    end

    // Watchdog: ends the run after too many cycles without a beat on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule

// ----- sim.f -----
src/aps_pkg.sv
src/aps_front.sv
src/aps_cmd_queue.sv
src/aps_back.sv
src/annexb_parameter_set_extractor.sv
test/tb.sv
